// ----- hdl/svm_pkg.sv -----
// svm_pkg: opcodes, status codes, sequencer states, divider request/response types
// and defaults of the stack VM execute unit. No dependencies.
package svm_pkg;
	localparam int unsigned MemWordsDefault  = 8192;
	localparam int unsigned ProgWordsDefault = 65536;

	typedef enum logic [7:0] {
		OP_LEA = 8'd0, OP_IMM = 8'd1, OP_JMP = 8'd2, OP_JSR = 8'd3, OP_BZ = 8'd4,
		OP_BNZ = 8'd5, OP_ENT = 8'd6, OP_ADJ = 8'd7, OP_LEV = 8'd8, OP_LI = 8'd9,
		OP_LC = 8'd10, OP_SI = 8'd11, OP_SC = 8'd12, OP_PSH = 8'd13, OP_OR = 8'd14,
		OP_XOR = 8'd15, OP_AND = 8'd16, OP_EQ = 8'd17, OP_NE = 8'd18, OP_LT = 8'd19,
		OP_GT = 8'd20, OP_LE = 8'd21, OP_GE = 8'd22, OP_SHL = 8'd23, OP_SHR = 8'd24,
		OP_ADD = 8'd25, OP_SUB = 8'd26, OP_MUL = 8'd27, OP_DIV = 8'd28, OP_MOD = 8'd29,
		OP_OPEN = 8'd30, OP_MCMP = 8'd36, OP_EXIT = 8'd37
	} opcode_t;

	typedef enum logic [2:0] {
		ST_RUN = 3'd0, ST_EXITED = 3'd1, ST_BAD_OP = 3'd2, ST_LIB = 3'd3,
		ST_DIV0 = 3'd4, ST_ADDR = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD1, S_RD2, S_EXEC, S_MUL_LO, S_MUL_HI, S_DIV, S_DIV_END, S_WR_DONE, S_OUT
	} seq_state_t;

	typedef struct packed {
		logic start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [63:0] quot;
		logic [63:0] rem;
	} div_rsp_t;
endpackage

// ----- hdl/svm_if.sv -----
// svm_if: valid/ready channel carrying one item.
// Depends on nothing; payload type is a parameter.
interface svm_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/svm_div.sv -----
// svm_div: unsigned 64-bit restoring divider, one quotient bit a cycle.
// Depends on svm_pkg.
module svm_div (
	input  logic clk,
	input  logic arst_n,
	input  svm_pkg::div_req_t req,
	output svm_pkg::div_rsp_t rsp
);
	import svm_pkg::*;
	logic [63:0] q_q, r_q, d_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] trial;

	assign trial = {r_q, q_q[63]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend;
			r_q <= '0;
			d_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[62:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = q_q;
	assign rsp.rem  = r_q;
endmodule

// ----- hdl/stack_vm_execute_unit_top.sv -----
// stack_vm_execute_unit_top: c4 stack machine execute unit with its data memory.
// Depends on svm_pkg, svm_if and svm_div.
//
// Channel  Dir  Payload
// in_ch    in   kind[7:0], operand[63:0]
// out_ch   out  accumulator[63:0], next_pc[15:0], status[2:0], exit_code[63:0]
// cfg      in   cfg_we, cfg_wdata[15:0] (entry_address)
//
// Sequencing: one item at a time. Most instructions pass accept, memory read,
// execute/write, output; LEV, SI and SC add a second read on the one memory
// port, MUL adds MUL_LO and MUL_HI (three 32x32 partial products), DIV/MOD wait
// on the bit-serial divider. Output register holds the result until taken; the
// next item is accepted once it leaves. Reset clears control state only; data
// memory contents are undefined until written, so no clearing pass.
module stack_vm_execute_unit_top #(
	parameter int unsigned MEM_WORDS  = svm_pkg::MemWordsDefault,
	parameter int unsigned PROG_WORDS = svm_pkg::ProgWordsDefault
) (
	input  logic clk,
	input  logic arst_n,
	svm_if.sink   in_ch,
	svm_if.source out_ch,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import svm_pkg::*;

	localparam int unsigned AW = $clog2(MEM_WORDS);
	localparam int unsigned SW = AW + 1;           // pointers reach MEM_WORDS
	localparam logic [63:0] MEMW  = 64'(MEM_WORDS);
	localparam logic [63:0] PROGW = 64'(PROG_WORDS);
	localparam logic [63:0] BYTES = 64'(MEM_WORDS) * 64'd8;

	// Data memory: one port, registered read.
	logic [63:0] mem [MEM_WORDS];
	logic [AW-1:0] mem_addr;
	logic          mem_we;
	logic [63:0]   mem_wdata, mem_rdata;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		mem_rdata <= mem[mem_addr];
	end

	// Architectural state
	seq_state_t state_q, state_d;
	logic [63:0] acc_q;
	logic [15:0] pc_q, entry_q;
	logic [SW-1:0] sp_q, fp_q;
	logic halted_q, started_q;
	status_t hst_q;
	// Item being executed
	logic [7:0]  kind_q;
	logic [63:0] opnd_q, rd1_q;
	// Output register
	logic        ovalid_q;
	logic [63:0] oacc_q, oex_q;
	logic [15:0] opc_q;
	status_t     ost_q;
	// Multiply partials, divider request and response
	logic [63:0] pll_q, plh_q, phl_q;
	div_req_t dreq;
	div_rsp_t drsp;
	svm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [15:0] pc1, pc2;
	logic [63:0] pcw1, pcw2;
	assign pcw1 = (64'(pc_q) + 64'd1) % PROGW;
	assign pcw2 = (64'(pc_q) + 64'd2) % PROGW;
	assign pc1 = pcw1[15:0];
	assign pc2 = pcw2[15:0];

	logic tgt;
	assign tgt = opnd_q < PROGW;

	function automatic logic [AW-1:0] widx(input logic [63:0] a);
		logic [63:0] s;
		s = a >> 3;
		return s[AW-1:0];
	endfunction

	// Binary operators, OR through MOD
	logic is_bin;
	assign is_bin = kind_q >= 8'(OP_OR) && kind_q <= 8'(OP_MOD);

	// Combinational execute results
	logic [63:0] x, y, alu, na, nb, rw, wword;
	logic [5:0]  sh;
	logic        fault, div0;
	always_comb begin
		x = rd1_q; y = acc_q;
		case (kind_q)
			8'(OP_OR):  alu = x | y;
			8'(OP_XOR): alu = x ^ y;
			8'(OP_AND): alu = x & y;
			8'(OP_EQ):  alu = 64'(x == y);
			8'(OP_NE):  alu = 64'(x != y);
			8'(OP_LT):  alu = 64'($signed(x) < $signed(y));
			8'(OP_GT):  alu = 64'($signed(x) > $signed(y));
			8'(OP_LE):  alu = 64'($signed(x) <= $signed(y));
			8'(OP_GE):  alu = 64'($signed(x) >= $signed(y));
			8'(OP_SHL): alu = (y >= 64'd64) ? 64'd0 : x << y[5:0];
			8'(OP_SHR): alu = (y >= 64'd64) ? {64{x[63]}} : 64'($signed(x) >>> y[5:0]);
			8'(OP_ADD): alu = x + y;
			8'(OP_SUB): alu = x - y;
			default:    alu = 64'd0;
		endcase
		na = x[63] ? -x : x;
		nb = y[63] ? -y : y;
		sh = 6'(acc_q[2:0]) << 3;
		rw = mem_rdata >> sh;
		// store merge: rd1_q is address, mem_rdata the target word
		if (kind_q == 8'(OP_SI))
			wword = (mem_rdata & ~(64'hFFFF_FFFF << (6'(rd1_q[2:0]) << 3)))
				| ((acc_q & 64'hFFFF_FFFF) << (6'(rd1_q[2:0]) << 3));
		else
			wword = (mem_rdata & ~(64'hFF << (6'(rd1_q[2:0]) << 3)))
				| ((acc_q & 64'hFF) << (6'(rd1_q[2:0]) << 3));
		fault = 1'b0; div0 = 1'b0;
	end

	// Sequencer
	logic [63:0] t_ent, t_adj;
	logic        sp_empty, sp_zero;
	assign sp_empty = 64'(sp_q) >= MEMW;
	assign sp_zero  = sp_q == '0;
	assign t_ent = 64'(sp_q) - 64'd1 - opnd_q;
	assign t_adj = 64'(sp_q) + opnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0; mem_addr = sp_q[AW-1:0]; mem_wdata = acc_q;
		dreq.start = 1'b0; dreq.dividend = na; dreq.divisor = nb;
		case (state_q)
			S_IDLE: if (in_ch.valid && !ovalid_q) state_d = S_RD1;
			S_RD1: begin
				// first read address
				if (kind_q == 8'(OP_LEV)) mem_addr = fp_q[AW-1:0];
				else if (kind_q == 8'(OP_LI) || kind_q == 8'(OP_LC))
					mem_addr = widx(acc_q);
				else mem_addr = sp_q[AW-1:0];
				state_d = (kind_q == 8'(OP_LEV) || kind_q == 8'(OP_SI)
					|| kind_q == 8'(OP_SC)) ? S_RD2 : S_EXEC;
			end
			S_RD2: begin
				if (kind_q == 8'(OP_LEV)) mem_addr = AW'(fp_q + SW'(1));
				else mem_addr = widx(mem_rdata);
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_OUT;
				if (!halted_q) begin
					if (kind_q == 8'(OP_MUL) && !sp_empty) state_d = S_MUL_LO;
					else if ((kind_q == 8'(OP_DIV) || kind_q == 8'(OP_MOD))
						&& !sp_empty && acc_q != 0) begin
						dreq.start = 1'b1; state_d = S_DIV;
					end
					case (kind_q)
						8'(OP_JSR): if (tgt && !sp_zero) begin
							mem_we = 1'b1; mem_addr = AW'(sp_q - SW'(1));
							mem_wdata = 64'(pc2);
						end
						8'(OP_ENT): if (!sp_zero && t_ent <= MEMW) begin
							mem_we = 1'b1; mem_addr = AW'(sp_q - SW'(1));
							mem_wdata = 64'(fp_q);
						end
						8'(OP_PSH): if (!sp_zero) begin
							mem_we = 1'b1; mem_addr = AW'(sp_q - SW'(1));
						end
						8'(OP_SI): if (!sp_empty && rd1_q < BYTES && rd1_q[1:0] == 2'b0) begin
							mem_we = 1'b1; mem_addr = widx(rd1_q); mem_wdata = wword;
						end
						8'(OP_SC): if (!sp_empty && rd1_q < BYTES) begin
							mem_we = 1'b1; mem_addr = widx(rd1_q); mem_wdata = wword;
						end
						default: ;
					endcase
				end
			end
			S_MUL_LO: state_d = S_MUL_HI;
			S_MUL_HI: state_d = S_OUT;
			S_DIV: if (drsp.done) state_d = S_DIV_END;
			S_DIV_END: state_d = S_OUT;
			S_WR_DONE: state_d = S_OUT;
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ch.ready = state_q == S_IDLE && !ovalid_q;

	// Datapath and state updates
	status_t st;
	logic [63:0] nacc, ex;
	logic [15:0] npc;
	logic [SW-1:0] nsp, nfp;
	always_comb begin
		st = ST_RUN; nacc = acc_q; ex = 64'd0; npc = pc1; nsp = sp_q; nfp = fp_q;
		case (kind_q)
			8'(OP_LEA): begin nacc = (64'(fp_q) + opnd_q) << 3; npc = pc2; end
			8'(OP_IMM): begin nacc = opnd_q; npc = pc2; end
			8'(OP_JMP): if (!tgt) st = ST_ADDR; else npc = opnd_q[15:0];
			8'(OP_JSR): if (!tgt || sp_zero) st = ST_ADDR;
				else begin nsp = sp_q - SW'(1); npc = opnd_q[15:0]; end
			8'(OP_BZ), 8'(OP_BNZ):
				if ((kind_q == 8'(OP_BZ)) == (acc_q == 64'd0)) begin
					if (!tgt) st = ST_ADDR; else npc = opnd_q[15:0];
				end else npc = pc2;
			8'(OP_ENT): if (sp_zero || t_ent > MEMW) st = ST_ADDR;
				else begin nfp = sp_q - SW'(1); nsp = SW'(t_ent); npc = pc2; end
			8'(OP_ADJ): if (t_adj > MEMW) st = ST_ADDR;
				else begin nsp = SW'(t_adj); npc = pc2; end
			8'(OP_LEV): if (64'(fp_q) + 64'd2 > MEMW || rd1_q > MEMW
				|| mem_rdata >= PROGW) st = ST_ADDR;
				else begin nsp = fp_q + SW'(2); nfp = SW'(rd1_q); npc = mem_rdata[15:0]; end
			8'(OP_LI): if (!(acc_q < BYTES && acc_q[1:0] == 2'b0)) st = ST_ADDR;
				else nacc = {{32{rw[31]}}, rw[31:0]};
			8'(OP_LC): if (!(acc_q < BYTES)) st = ST_ADDR;
				else nacc = {{56{rw[7]}}, rw[7:0]};
			8'(OP_SI): if (sp_empty || !(rd1_q < BYTES && rd1_q[1:0] == 2'b0))
				st = ST_ADDR; else nsp = sp_q + SW'(1);
			8'(OP_SC): if (sp_empty || !(rd1_q < BYTES)) st = ST_ADDR;
				else begin nsp = sp_q + SW'(1); nacc = {{56{acc_q[7]}}, acc_q[7:0]}; end
			8'(OP_PSH): if (sp_zero) st = ST_ADDR; else nsp = sp_q - SW'(1);
			8'(OP_EXIT): if (sp_empty) st = ST_ADDR;
				else begin ex = rd1_q; st = ST_EXITED; end
			default:
				if (is_bin) begin
					if (sp_empty) st = ST_ADDR;
					else if ((kind_q == 8'(OP_DIV) || kind_q == 8'(OP_MOD)) && acc_q == 0)
						st = ST_DIV0;
					else begin nacc = alu; nsp = sp_q + SW'(1); end
				end else if (kind_q >= 8'(OP_OPEN) && kind_q <= 8'(OP_MCMP)) st = ST_LIB;
				else st = ST_BAD_OP;
		endcase
	end

	logic [63:0] mres;
	assign mres = pll_q + ((plh_q + phl_q) << 32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; pc_q <= '0; entry_q <= '0; sp_q <= SW'(MEM_WORDS); fp_q <= '0;
			halted_q <= 1'b0; started_q <= 1'b0; hst_q <= ST_RUN; ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				entry_q <= cfg_wdata;
				if (!started_q) pc_q <= 16'((64'(cfg_wdata)) % PROGW);
			end
			if (out_ch.ready && ovalid_q) ovalid_q <= 1'b0;
			if (in_ch.valid && in_ch.ready) started_q <= 1'b1;
			if (state_q == S_EXEC && !halted_q) begin
				if (st != ST_RUN) begin
					halted_q <= 1'b1; hst_q <= st;
				end else if (state_d == S_OUT) begin
					acc_q <= nacc; pc_q <= npc; sp_q <= nsp; fp_q <= nfp;
				end
			end
			if (state_q == S_MUL_HI) begin
				acc_q <= mres; pc_q <= pc1; sp_q <= sp_q + SW'(1);
			end
			if (state_q == S_DIV_END) begin
				if (kind_q == 8'(OP_DIV))
					acc_q <= (rd1_q[63] ^ acc_q[63]) ? -drsp.quot : drsp.quot;
				else
					acc_q <= rd1_q[63] ? -drsp.rem : drsp.rem;
				pc_q <= pc1; sp_q <= sp_q + SW'(1);
			end
			if (state_q == S_OUT) ovalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			kind_q <= in_ch.payload.kind;
			opnd_q <= in_ch.payload.operand;
		end
		if (state_q == S_RD1 || (state_q == S_RD2 && kind_q != 8'(OP_LEV))) rd1_q <= mem_rdata;
		if (state_q == S_RD2 && kind_q == 8'(OP_LEV)) rd1_q <= mem_rdata;
		if (state_q == S_EXEC) begin
			oex_q <= (halted_q || st != ST_EXITED) ? 64'd0 : ex;
			pll_q <= 64'(rd1_q[31:0]) * 64'(acc_q[31:0]);
			plh_q <= 64'(rd1_q[31:0]) * 64'(acc_q[63:32]);
			phl_q <= 64'(rd1_q[63:32]) * 64'(acc_q[31:0]);
		end
		if (state_q == S_OUT) begin
			oacc_q <= acc_q; opc_q <= pc_q; ost_q <= hst_q;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.payload.accumulator = oacc_q;
	assign out_ch.payload.next_pc     = opc_q;
	assign out_ch.payload.status      = ost_q;
	assign out_ch.payload.exit_code   = oex_q;

	logic unused;
	assign unused = ^{entry_q, fault, div0, drsp.busy};
endmodule
